// ===== rtl/mdr_pkg.sv =====
// Shared types for the rounded multiply-divide pipeline.
package mdr_pkg;

  typedef struct packed {
    logic valid;
    logic neg;
    logic ovf;
  } mdr_ctl_t;

endpackage

// ===== rtl/multiply_divide_rounded.sv =====
// Rounded signed multiply-divide pipeline: round(a * b / c) with overflow flag.
// Stages: magnitudes, partial products, product, range check, divider, round, output.
// Throughput: one transaction per cycle; busy stays low and start may be held high.
// Depth is set by the restoring divider, one registered step per quotient bit.
// Synchronous active-low reset clears all valid bits; no result is lost to stall.
module multiply_divide_rounded #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_factor_a,
  input  logic signed [31:0] in_factor_b,
  input  logic signed [31:0] in_divisor,
  output logic               out_valid,
  output logic signed [31:0] out_quotient,
  output logic               out_overflow
);

  localparam int W    = DATA_WIDTH;
  localparam int LO_W = DATA_WIDTH / 2;
  localparam int HI_W = DATA_WIDTH - LO_W;
  localparam int PW   = 2 * DATA_WIDTH;
  localparam logic [DATA_WIDTH:0] HALF_RANGE = {2'b01, {(DATA_WIDTH-1){1'b0}}};

  // stage 1: magnitudes and result sign
  logic [W-1:0] a_w, b_w, c_w;
  logic [W-1:0] ma_nxt, mb_nxt, mc_nxt;
  logic         neg_nxt;
  mdr_pkg::mdr_ctl_t s1_ctl_r, s1_ctl_nxt;
  logic [W-1:0] s1_ma_r, s1_mb_r, s1_mc_r;

  always_comb begin
    a_w        = in_factor_a[W-1:0];
    b_w        = in_factor_b[W-1:0];
    c_w        = in_divisor[W-1:0];
    ma_nxt     = a_w[W-1] ? (~a_w + 1'b1) : a_w;
    mb_nxt     = b_w[W-1] ? (~b_w + 1'b1) : b_w;
    mc_nxt     = c_w[W-1] ? (~c_w + 1'b1) : c_w;
    neg_nxt    = a_w[W-1] ^ b_w[W-1] ^ c_w[W-1];
    s1_ctl_nxt = '{valid: start & ~busy, neg: neg_nxt, ovf: 1'b0};
  end

  // stage 2: partial products
  mdr_pkg::mdr_ctl_t s2_ctl_r;
  logic [W-1:0]         s2_mc_r;
  logic [2*LO_W-1:0]    s2_pp_ll_r;
  logic [LO_W+HI_W-1:0] s2_pp_lh_r, s2_pp_hl_r;
  logic [2*HI_W-1:0]    s2_pp_hh_r;

  // stage 3: full product
  mdr_pkg::mdr_ctl_t s3_ctl_r;
  logic [W-1:0]  s3_mc_r;
  logic [PW-1:0] s3_prod_r, prod_nxt;

  always_comb begin
    prod_nxt = (PW'(s2_pp_hh_r) << (2 * LO_W))
             + ((PW'(s2_pp_lh_r) + PW'(s2_pp_hl_r)) << LO_W)
             + PW'(s2_pp_ll_r);
  end

  // stage 4: high-half range check, divider entry
  mdr_pkg::mdr_ctl_t ctl_s [0:W];
  logic [W-1:0]      rem_s [0:W];
  logic [W-1:0]      lq_s  [0:W];
  logic [W-1:0]      dvs_s [0:W];
  mdr_pkg::mdr_ctl_t s4_ctl_r, s4_ctl_nxt;
  logic [W-1:0]      s4_rem_r, s4_lq_r, s4_mc_r;

  always_comb begin
    s4_ctl_nxt     = s3_ctl_r;
    s4_ctl_nxt.ovf = s3_prod_r[PW-1:W] >= s3_mc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s4_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ma_r    <= ma_nxt;
    s1_mb_r    <= mb_nxt;
    s1_mc_r    <= mc_nxt;
    s2_mc_r    <= s1_mc_r;
    s2_pp_ll_r <= s1_ma_r[LO_W-1:0] * s1_mb_r[LO_W-1:0];
    s2_pp_lh_r <= s1_ma_r[LO_W-1:0] * s1_mb_r[W-1:LO_W];
    s2_pp_hl_r <= s1_ma_r[W-1:LO_W] * s1_mb_r[LO_W-1:0];
    s2_pp_hh_r <= s1_ma_r[W-1:LO_W] * s1_mb_r[W-1:LO_W];
    s3_mc_r    <= s2_mc_r;
    s3_prod_r  <= prod_nxt;
    s4_rem_r   <= s3_prod_r[PW-1:W];
    s4_lq_r    <= s3_prod_r[W-1:0];
    s4_mc_r    <= s3_mc_r;
  end

  assign ctl_s[0] = s4_ctl_r;
  assign rem_s[0] = s4_rem_r;
  assign lq_s[0]  = s4_lq_r;
  assign dvs_s[0] = s4_mc_r;

  for (genvar i = 0; i < W; i++) begin : g_div
    mdr_div_step #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_step (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl_i(ctl_s[i]),
      .rem_i(rem_s[i]),
      .lq_i (lq_s[i]),
      .dvs_i(dvs_s[i]),
      .ctl_o(ctl_s[i+1]),
      .rem_o(rem_s[i+1]),
      .lq_o (lq_s[i+1]),
      .dvs_o(dvs_s[i+1])
    );
  end

  // rounding stage: half away from zero on the magnitude
  mdr_pkg::mdr_ctl_t rnd_ctl_r;
  logic [W:0] rnd_q_r, rnd_q_nxt;
  logic       rnd_up;

  always_comb begin
    rnd_up    = {rem_s[W], 1'b0} >= {1'b0, dvs_s[W]};
    rnd_q_nxt = {1'b0, lq_s[W]} + {{W{1'b0}}, rnd_up};
  end

  // output stage: range check, sign, sign extension
  logic         oor;
  logic [W-1:0] val;
  logic         out_valid_r, out_overflow_r;
  logic signed [31:0] out_quotient_r, out_quotient_nxt;

  always_comb begin
    oor = rnd_ctl_r.neg ? (rnd_q_r > HALF_RANGE) : (rnd_q_r >= HALF_RANGE);
    val = rnd_ctl_r.neg ? (~rnd_q_r[W-1:0] + 1'b1) : rnd_q_r[W-1:0];
    if (rnd_ctl_r.ovf || oor) begin
      out_quotient_nxt = '0;
    end else begin
      out_quotient_nxt = 32'(signed'(val));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_ctl_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rnd_ctl_r   <= ctl_s[W];
      out_valid_r <= rnd_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    rnd_q_r        <= rnd_q_nxt;
    out_quotient_r <= out_quotient_nxt;
    out_overflow_r <= rnd_ctl_r.ovf | oor;
  end

  assign busy         = 1'b0;
  assign out_valid    = out_valid_r;
  assign out_quotient = out_quotient_r;
  assign out_overflow = out_overflow_r;

endmodule

// ===== rtl/mdr_div_step.sv =====
// One registered restoring-division step: a trial subtract and a quotient bit.
module mdr_div_step #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mdr_pkg::mdr_ctl_t     ctl_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] lq_i,
  input  logic [DATA_WIDTH-1:0] dvs_i,
  output mdr_pkg::mdr_ctl_t     ctl_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] lq_o,
  output logic [DATA_WIDTH-1:0] dvs_o
);

  mdr_pkg::mdr_ctl_t     ctl_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] lq_r, lq_nxt;
  logic [DATA_WIDTH-1:0] dvs_r;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  // lq holds the unconsumed low dividend bits on top, quotient bits shift in below
  always_comb begin
    trial   = {rem_i, lq_i[DATA_WIDTH-1]};
    diff    = trial - {1'b0, dvs_i};
    ge      = trial >= {1'b0, dvs_i};
    rem_nxt = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    lq_nxt  = {lq_i[DATA_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lq_r  <= lq_nxt;
    dvs_r <= dvs_i;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign lq_o  = lq_r;
  assign dvs_o = dvs_r;

endmodule
